// ===== sv/assert_macros.svh =====
// Assertion macros shared by the battery-average RTL.
// Files that check their own logic include this header by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst_n is low.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dcba_pkg.sv =====
// Package for the dual-channel battery average: widths, reset values,
// register and channel codes, and the structs passed between stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcba_pkg;

  // Sample and averaging window
  localparam int SAMPLE_W = 10;
  localparam int WIN_LOG  = 3;
  localparam int WINDOW   = 1 << WIN_LOG;
  localparam int IDX_W    = WIN_LOG;
  localparam int SUM_W    = SAMPLE_W + WIN_LOG;
  localparam int SUM_MAX  = WINDOW * ((1 << SAMPLE_W) - 1);

  // Gains and scaled results
  localparam int GAIN_W      = 12;
  localparam int PROD_W      = GAIN_W + SAMPLE_W;
  localparam int TOTAL_SHIFT = 10;
  localparam int LOWER_SHIFT = 11;
  localparam int UPPER_W     = 12;
  localparam int LOWER_W     = 11;

  localparam logic [GAIN_W-1:0] TOTAL_GAIN_RST = 12'd1650;
  localparam logic [GAIN_W-1:0] LOWER_GAIN_RST = 12'd1500;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_GAIN = 1'b1;

  // Channel codes
  localparam logic CH_TOTAL = 1'b0;
  localparam logic CH_LOWER = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [GAIN_W-1:0]   gain_t;
  typedef logic [UPPER_W-1:0]  upper_t;
  typedef logic [LOWER_W-1:0]  lower_t;

  // Averages after one sample update
  typedef struct packed {
    logic    channel;
    sample_t total_avg;
    sample_t lower_avg;
  } avg_pair_t;

  // Scaled voltages before the final subtract
  typedef struct packed {
    logic   channel;
    upper_t pack;
    lower_t lower;
  } scaled_t;

endpackage

`default_nettype wire

// ===== sv/dcba_if.sv =====
// Valid/ready channel interfaces for the battery average block.
// Depends on dcba_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

// Sample channel
interface dcba_in_if;
  logic              valid;
  logic              ready;
  dcba_pkg::sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// Result channel
interface dcba_out_if;
  logic             valid;
  logic             ready;
  logic             sample_channel;
  dcba_pkg::upper_t upper_decivolts;
  dcba_pkg::lower_t lower_decivolts;

  modport source (output valid, output sample_channel, output upper_decivolts,
                  output lower_decivolts, input ready);
  modport sink   (input valid, input sample_channel, input upper_decivolts,
                  input lower_decivolts, output ready);
endinterface

`default_nettype wire

// ===== sv/dcba_chan_avg.sv =====
// One channel of the moving average: sample ring, oldest-slot pointer
// and running sum. Depends on dcba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dcba_chan_avg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dcba_pkg::sample_t sample,
  output dcba_pkg::sum_t    sum_nxt
);
  import dcba_pkg::*;

  sample_t          ring_r [WINDOW];
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  sum_t             sum_r;

  // Replace the oldest entry in the sum; pass the sum through otherwise
  always_comb begin
    sum_nxt = sum_r;
    if (push) begin
      sum_nxt = sum_r - SUM_W'(ring_r[idx_r]) + SUM_W'(sample);
    end
  end

  // Pointer wraps after the last slot
  always_comb begin
    if (idx_r == IDX_W'(WINDOW - 1)) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // Ring, pointer and sum; reset empties the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring_r[k] <= '0;
      end
      idx_r <= '0;
      sum_r <= '0;
    end else if (push) begin
      ring_r[idx_r] <= sample;
      idx_r         <= idx_nxt;
      sum_r         <= sum_nxt;
    end
  end

  // The running sum never exceeds a ring full of maximum samples
  `ASSERT_CLKD(a_sum_bound, sum_r <= SUM_W'(SUM_MAX), "channel sum out of range")

endmodule

`default_nettype wire

// ===== sv/dcba_scale.sv =====
// Result pipeline: average register, gain multiply, subtract and output
// register, with per-stage valid bits. Depends on dcba_pkg and dcba_if.
`timescale 1ns / 1ps
`default_nettype none

module dcba_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dcba_pkg::avg_pair_t  in_pair,
  input  dcba_pkg::gain_t      total_gain,
  input  dcba_pkg::gain_t      lower_gain,
  dcba_out_if.source           out_ch
);
  import dcba_pkg::*;

  logic        s1_valid_r;
  avg_pair_t   s1_r;
  logic        s2_valid_r;
  scaled_t     s2_r;
  scaled_t     s2_nxt;
  logic        out_valid_r;
  logic        out_ch_r;
  upper_t      upper_r;
  upper_t      upper_nxt;
  lower_t      lower_r;
  logic [PROD_W-1:0] total_prod;
  logic [PROD_W-1:0] lower_prod;
  logic        out_adv;
  logic        s2_adv;
  logic        s1_adv;

  // A stage moves when it is empty or the next one moves
  assign out_adv  = !out_valid_r || out_ch.ready;
  assign s2_adv   = !s2_valid_r || out_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;

  // Stage 1: averages of this transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_r <= in_pair;
    end
  end

  // Stage 2: gain multiply and fixed-point shift
  always_comb begin
    total_prod     = PROD_W'(total_gain) * PROD_W'(s1_r.total_avg);
    lower_prod     = PROD_W'(lower_gain) * PROD_W'(s1_r.lower_avg);
    s2_nxt.channel = s1_r.channel;
    s2_nxt.pack    = total_prod[TOTAL_SHIFT +: UPPER_W];
    s2_nxt.lower   = lower_prod[LOWER_SHIFT +: LOWER_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: upper = pack - lower, floored at zero
  always_comb begin
    if (s2_r.pack > UPPER_W'(s2_r.lower)) begin
      upper_nxt = s2_r.pack - UPPER_W'(s2_r.lower);
    end else begin
      upper_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid_r) begin
      out_ch_r <= s2_r.channel;
      upper_r  <= upper_nxt;
      lower_r  <= s2_r.lower;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sample_channel  = out_ch_r;
  assign out_ch.upper_decivolts = upper_r;
  assign out_ch.lower_decivolts = lower_r;

endmodule

`default_nettype wire

// ===== sv/dual_channel_battery_average.sv =====
// A result passes the stage 1, stage 2 and output registers after its sample transaction is accepted.
// Throughput: one sample per cycle; the three-stage result pipeline keeps
// taking samples until all stages hold results the sink has not taken.
// Reset (rst_n low at a clock edge): rings, sums, pointers and valid bits
// clear, gains return to 1650 and 1500, the first sample goes to pack total.
// Depends on dcba_pkg, dcba_if, dcba_chan_avg, dcba_scale, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dual_channel_battery_average (
  input  logic                             clk,
  input  logic                             rst_n,
  dcba_in_if.sink                          in_ch,
  dcba_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [dcba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcba_pkg::GAIN_W-1:0]      cfg_wdata
);
  import dcba_pkg::*;

  gain_t     total_gain_r;
  gain_t     lower_gain_r;
  logic      next_channel_r;
  logic      accept;
  logic      push_total;
  logic      push_lower;
  logic      scale_ready;
  sum_t      total_sum_nxt;
  sum_t      lower_sum_nxt;
  avg_pair_t pair;

  // Gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_gain_r <= TOTAL_GAIN_RST;
      lower_gain_r <= LOWER_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_GAIN: total_gain_r <= cfg_wdata;
        CFG_LOWER_GAIN: lower_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Channel steering: samples alternate, pack total first
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_total  = accept && (next_channel_r == CH_TOTAL);
  assign push_lower  = accept && (next_channel_r == CH_LOWER);
  assign in_ch.ready = scale_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_channel_r <= CH_TOTAL;
    end else if (accept) begin
      next_channel_r <= ~next_channel_r;
    end
  end

  dcba_chan_avg u_total (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push_total),
    .sample  (in_ch.adc_sample),
    .sum_nxt (total_sum_nxt)
  );

  dcba_chan_avg u_lower (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push_lower),
    .sample  (in_ch.adc_sample),
    .sum_nxt (lower_sum_nxt)
  );

  // Averages after this sample's update: sum over the window
  always_comb begin
    pair.channel   = next_channel_r;
    pair.total_avg = total_sum_nxt[SUM_W-1:WIN_LOG];
    pair.lower_avg = lower_sum_nxt[SUM_W-1:WIN_LOG];
  end

  dcba_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (scale_ready),
    .in_pair    (pair),
    .total_gain (total_gain_r),
    .lower_gain (lower_gain_r),
    .out_ch     (out_ch)
  );

  // Each accepted transaction flips the channel for the next one
  `ASSERT_CLKD(a_chan_toggle, accept |=> next_channel_r != $past(next_channel_r), "channel stuck")
  // An empty output register means the pipeline can take a sample
  `ASSERT_CLKD(a_ready_when_drained, !out_ch.valid |-> in_ch.ready, "stalled with empty output")
  // No result is offered right after reset
  `ASSERT_CLK(a_reset_idle, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule

`default_nettype wire
